>>> src/tbo_pkg.sv
// shared constants for the triangle / cube overlap pipeline
// no dependencies
`default_nettype none
package tbo_pkg;

  // default coordinate width in bits
  localparam int COORD_WIDTH = 32;
  // width of half size and tolerance registers
  localparam int HALF_WIDTH  = 31;
  localparam int TOL_WIDTH   = 18;
  // effective half size width: half plus signed tolerance
  localparam int H_WIDTH     = 33;
  // edge axis bias, 1.0e-4 in Q32.32
  localparam int unsigned EDGE_BIAS = 429497;
  // reset value of half size, 1.0 in Q16.16
  localparam int unsigned HALF_RESET = 65536;

  localparam int CFG_IDX_WIDTH = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_HALF     = 3'd3,
    CFG_TOL      = 3'd4
  } cfg_idx_t;

endpackage
`default_nettype wire

>>> src/triangle_box_overlap.sv
// triangle against axis-aligned cube overlap test, separating axis method
// depends on tbo_pkg
`default_nettype none
// One triangle is taken per clock when start is high; busy is always low, so
// the block never refuses a beat. The answer appears on out_overlaps with
// out_valid high for one cycle, once the triangle has passed stages A to F.
// The pipeline keeps one result per cycle: stage A registers the beat,
// B forms vertex offsets and the face tests, C holds the multipliers, D the
// sums of products, E the normal test and edge sums, F the edge compares.
// The receiver cannot stall the result. Configure the cube only while no
// triangle is in flight; cfg_ready is always high.
module triangle_box_overlap #(
  parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire signed [COORD_WIDTH-1:0]        in_normal_x,
  input  wire signed [COORD_WIDTH-1:0]        in_normal_y,
  input  wire signed [COORD_WIDTH-1:0]        in_normal_z,
  input  wire signed [COORD_WIDTH-1:0]        in_vert0_x,
  input  wire signed [COORD_WIDTH-1:0]        in_vert0_y,
  input  wire signed [COORD_WIDTH-1:0]        in_vert0_z,
  input  wire signed [COORD_WIDTH-1:0]        in_vert1_x,
  input  wire signed [COORD_WIDTH-1:0]        in_vert1_y,
  input  wire signed [COORD_WIDTH-1:0]        in_vert1_z,
  input  wire signed [COORD_WIDTH-1:0]        in_vert2_x,
  input  wire signed [COORD_WIDTH-1:0]        in_vert2_y,
  input  wire signed [COORD_WIDTH-1:0]        in_vert2_z,
  output logic                                out_valid,
  output logic                                out_overlaps,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [tbo_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  wire [((COORD_WIDTH > tbo_pkg::HALF_WIDTH) ? COORD_WIDTH
               : tbo_pkg::HALF_WIDTH)-1:0]    cfg_wdata
);

  localparam int W    = COORD_WIDTH;
  localparam int HW   = tbo_pkg::H_WIDTH;
  localparam int HALW = tbo_pkg::HALF_WIDTH;
  localparam int TW   = tbo_pkg::TOL_WIDTH;
  // face bound width
  localparam int SW   = ((W > HW) ? W : HW) + 2;
  // vertex offset v = p - c
  localparam int VW   = W + 1;
  // edge magnitude
  localparam int EW   = W + 2;
  // coordinate products and h products
  localparam int PW   = 2 * VW;
  localparam int QW   = HW + EW;
  // common compare width
  localparam int CW   = ((2 * W + 6) > (W + 40)) ? (2 * W + 6) : (W + 40);

  // configuration registers
  logic signed [W-1:0]    center_r [3];
  logic        [HALW-1:0] half_r;
  logic signed [TW-1:0]   tol_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      half_r      <= HALW'(tbo_pkg::HALF_RESET);
      tol_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbo_pkg::CFG_CENTER_X: center_r[0] <= cfg_wdata[W-1:0];
        tbo_pkg::CFG_CENTER_Y: center_r[1] <= cfg_wdata[W-1:0];
        tbo_pkg::CFG_CENTER_Z: center_r[2] <= cfg_wdata[W-1:0];
        tbo_pkg::CFG_HALF:     half_r      <= cfg_wdata[HALW-1:0];
        tbo_pkg::CFG_TOL:      tol_r       <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // effective half size
  logic signed [HW-1:0] h;
  assign h = HW'(signed'({1'b0, half_r})) + HW'(tol_r);

  // stage A: register the accepted beat
  logic                va_r;
  logic signed [W-1:0] na_r [3];
  logic signed [W-1:0] pa_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    na_r[0]    <= in_normal_x;
    na_r[1]    <= in_normal_y;
    na_r[2]    <= in_normal_z;
    pa_r[0][0] <= in_vert0_x;
    pa_r[0][1] <= in_vert0_y;
    pa_r[0][2] <= in_vert0_z;
    pa_r[1][0] <= in_vert1_x;
    pa_r[1][1] <= in_vert1_y;
    pa_r[1][2] <= in_vert1_z;
    pa_r[2][0] <= in_vert2_x;
    pa_r[2][1] <= in_vert2_y;
    pa_r[2][2] <= in_vert2_z;
  end

  // stage B: offsets, edge magnitudes, face tests
  logic                 vb_r;
  logic                 face_sep_nxt, face_sep_r;
  logic signed [VW-1:0] v_nxt [3][3];
  logic signed [VW-1:0] v_r   [3][3];
  logic signed [EW-1:0] e_nxt [3][3];
  logic signed [EW-1:0] e_r   [3][3];
  logic signed [VW-1:0] nb_r  [3];
  logic signed [VW-1:0] nabs_r [3];
  logic signed [HW-1:0] hb_r;

  always_comb begin
    logic signed [SW-1:0] lo, hi;
    logic signed [EW-1:0] df;
    face_sep_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lo = SW'(center_r[i]) - SW'(h);
      hi = SW'(center_r[i]) + SW'(h);
      if (SW'(pa_r[0][i]) > hi && SW'(pa_r[1][i]) > hi && SW'(pa_r[2][i]) > hi)
        face_sep_nxt = 1'b1;
      if (SW'(pa_r[0][i]) < lo && SW'(pa_r[1][i]) < lo && SW'(pa_r[2][i]) < lo)
        face_sep_nxt = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        v_nxt[k][i] = VW'(pa_r[k][i]) - VW'(center_r[i]);
        df = EW'(pa_r[(k + 1) % 3][i]) - EW'(pa_r[k][i]);
        e_nxt[k][i] = (df < 0) ? -df : df;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    face_sep_r <= face_sep_nxt;
    v_r        <= v_nxt;
    e_r        <= e_nxt;
    hb_r       <= h;
    for (int i = 0; i < 3; i++) begin
      nb_r[i]   <= VW'(na_r[i]);
      nabs_r[i] <= (na_r[i] < 0) ? -VW'(na_r[i]) : VW'(na_r[i]);
    end
  end

  // stage C: all products
  logic                 vc_r;
  logic                 face_sep_c_r;
  logic signed [PW-1:0] dot_p_r [3];
  logic signed [QW-1:0] rad_p_r [3];
  logic signed [PW-1:0] ca_p_r  [3][3];
  logic signed [PW-1:0] cb_p_r  [3][3];
  logic signed [QW-1:0] he_p_r  [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    face_sep_c_r <= face_sep_r;
    for (int i = 0; i < 3; i++) begin
      dot_p_r[i] <= nb_r[i] * v_r[0][i];
      rad_p_r[i] <= QW'(hb_r) * QW'(nabs_r[i]);
    end
    // ct[k] = v[k+1] x v[k]
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ca_p_r[k][i] <= v_r[(k + 1) % 3][(i + 1) % 3] * v_r[k][(i + 2) % 3];
        cb_p_r[k][i] <= v_r[(k + 1) % 3][(i + 2) % 3] * v_r[k][(i + 1) % 3];
        he_p_r[k][i] <= QW'(hb_r) * QW'(e_r[k][i]);
      end
    end
  end

  // stage D: sums of products
  logic                 vd_r;
  logic                 face_sep_d_r;
  logic signed [CW-1:0] dot_r, rad_r;
  logic signed [CW-1:0] ct_r [3][3];
  logic signed [CW-1:0] d_r  [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else        vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    face_sep_d_r <= face_sep_c_r;
    dot_r <= CW'(dot_p_r[0]) + CW'(dot_p_r[1]) + CW'(dot_p_r[2]);
    rad_r <= CW'(rad_p_r[0]) + CW'(rad_p_r[1]) + CW'(rad_p_r[2]);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ct_r[k][i] <= CW'(ca_p_r[k][i]) - CW'(cb_p_r[k][i]);
        d_r[k][i]  <= CW'(he_p_r[k][(i + 1) % 3]) + CW'(he_p_r[k][(i + 2) % 3])
                    + CW'(tbo_pkg::EDGE_BIAS);
      end
    end
  end

  // stage E: normal axis test, edge side sums
  logic                 ve_r;
  logic                 sep_e_r;
  logic signed [CW-1:0] t_r  [3][3];
  logic signed [CW-1:0] s_r  [3][3];
  logic signed [CW-1:0] de_r [3][3];
  logic signed [CW-1:0] dot_abs;

  assign dot_abs = (dot_r < 0) ? -dot_r : dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else        ve_r <= vd_r;
  end

  always_ff @(posedge clk) begin
    sep_e_r <= face_sep_d_r || (dot_abs > rad_r);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        t_r[k][i]  <= ct_r[k][i];
        s_r[k][i]  <= ct_r[(k + 1) % 3][i] + ct_r[(k + 2) % 3][i];
        de_r[k][i] <= d_r[k][i];
      end
    end
  end

  // stage F: edge compares and result beat
  logic edge_sep;

  always_comb begin
    logic signed [CW-1:0] nd;
    edge_sep = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        nd = -de_r[k][i];
        if ((t_r[k][i] > de_r[k][i] && nd > s_r[k][i]) ||
            (nd > t_r[k][i] && s_r[k][i] > de_r[k][i]))
          edge_sep = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= ve_r;
  end

  always_ff @(posedge clk) begin
    out_overlaps <= !(sep_e_r || edge_sep);
  end

  // every result beat comes from a triangle taken in at the head of the pipeline
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result beat without matching triangle");

  // every taken triangle yields a result beat at the end of the pipeline
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("triangle lost in pipeline");

  // valid bits stay aligned through the middle of the pipeline
  a_stage_align: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |=> vd_r)
    else $error("pipeline valid bit dropped");

endmodule
`default_nettype wire
